[rtl/core/rhcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header check and strip package
// Shared types and constants for the RTP fixed-header checker.
// ----------------------------------------------------------------------------
package rhcs_pkg;

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned PT_W       = 7;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned SEQ_W      = 16;
    localparam int unsigned SRC_W      = 32;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    localparam logic [POS_W-1:0] POS_VERSION    = 4'd0;
    localparam logic [POS_W-1:0] POS_PTYPE      = 4'd1;
    localparam logic [POS_W-1:0] POS_SEQ_HI     = 4'd2;
    localparam logic [POS_W-1:0] POS_SEQ_LO     = 4'd3;
    localparam logic [POS_W-1:0] POS_SSRC_FIRST = 4'd8;
    localparam logic [POS_W-1:0] POS_SSRC_LAST  = 4'd11;
    localparam logic [POS_W-1:0] HDR_LAST       = 4'd11;
    localparam logic [POS_W-1:0] HDR_BYTES      = 4'd12;

    localparam logic [1:0]        RTP_VERSION  = 2'd2;
    localparam logic [DATA_W-1:0] VERSION_MASK = 8'hC0;
    localparam logic [DATA_W-1:0] PT_MASK      = 8'h7F;

    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCOUNT_W = $clog2(QDEPTH + 1);

    localparam logic REG_EXPECTED_PT = 1'b0;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_VERSION = 3'd1,
        ST_PTYPE   = 3'd2,
        ST_SEQGAP  = 3'd3,
        ST_SSRC    = 3'd4,
        ST_SHORT   = 3'd5
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] payload_byte;
        logic              payload_present;
        logic              packet_done;
        status_t           packet_status;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[rtl/core/rhcs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header check and strip channels
// Valid/ready channels for packet bytes in and results out.
// ----------------------------------------------------------------------------
interface rhcs_in_if;
    logic                           valid;
    logic                           ready;
    logic [rhcs_pkg::DATA_W-1:0]    data_byte;
    logic                           end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface rhcs_out_if;
    logic                           valid;
    logic                           ready;
    logic [rhcs_pkg::DATA_W-1:0]    payload_byte;
    logic                           payload_present;
    logic                           packet_done;
    logic [2:0]                     packet_status;

    modport source (output valid, output payload_byte, output payload_present,
                    output packet_done, output packet_status, input ready);
    modport sink (input valid, input payload_byte, input payload_present,
                  input packet_done, input packet_status, output ready);
endinterface

[rtl/core/rtp_header_check_and_strip.sv]
`timescale 1ns / 1ps
// A result passes through the queue and then the output register to the output channel.
// Throughput: one byte per cycle unless the queue is full; header checks are combinational.
// A four-entry queue and the output register absorb output stalls independently.
// Reset: rst_n is asynchronous and active low; it clears the header and stream state,
// empties the queue and sets expected_payload_type to zero.
// ----------------------------------------------------------------------------
// RTP header check and strip
// Checks the RTP fixed header of each packet and passes payload of valid ones.
// ----------------------------------------------------------------------------
module rtp_header_check_and_strip
(
    input  logic                                clk,
    input  logic                                rst_n,
    rhcs_in_if.sink                             in_ch,
    rhcs_out_if.source                          out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rhcs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rhcs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rhcs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [rhcs_pkg::PT_W-1:0] expected_pt_reg;
    rhcs_pkg::queue_status_t   queue_status;
    rhcs_pkg::item_t           push_item;
    rhcs_pkg::item_t           pop_item;
    logic                      push;
    logic                      pop;

    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == rhcs_pkg::REG_EXPECTED_PT)
        begin
            prdata = {{(rhcs_pkg::APB_DATA_W - rhcs_pkg::PT_W){1'b0}}, expected_pt_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pt_reg <= '0;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[2] == rhcs_pkg::REG_EXPECTED_PT))
        begin
            expected_pt_reg <= pwdata[rhcs_pkg::PT_W-1:0];
        end
    end

    rhcs_front u_front
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_ch                 (in_ch),
        .expected_payload_type (expected_pt_reg),
        .queue_status          (queue_status),
        .push                  (push),
        .push_item             (push_item)
    );

    rhcs_queue u_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_item    (push_item),
        .pop          (pop),
        .pop_item     (pop_item),
        .queue_status (queue_status)
    );

    rhcs_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .pop_item     (pop_item),
        .pop          (pop),
        .out_ch       (out_ch)
    );

endmodule

[rtl/core/rhcs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header check front end
// Accepts packet bytes, checks the fixed header and queues result items.
// ----------------------------------------------------------------------------
module rhcs_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    rhcs_in_if.sink                         in_ch,
    input  logic [rhcs_pkg::PT_W-1:0]       expected_payload_type,
    input  rhcs_pkg::queue_status_t         queue_status,
    output logic                            push,
    output rhcs_pkg::item_t                 push_item
);

    logic [rhcs_pkg::POS_W-1:0] pos_reg, pos_next;
    rhcs_pkg::status_t          verdict_reg, verdict_next;
    logic [rhcs_pkg::SEQ_W-1:0] cap_seq_reg, cap_seq_next;
    logic [rhcs_pkg::SRC_W-1:0] cap_src_reg, cap_src_next;
    logic [rhcs_pkg::SEQ_W-1:0] prev_seq_reg, prev_seq_next;
    logic [rhcs_pkg::SRC_W-1:0] locked_src_reg, locked_src_next;
    logic                       locked_reg, locked_next;
    logic                       accept;
    logic                       present;
    logic [rhcs_pkg::DATA_W-1:0] b;

    assign in_ch.ready = !queue_status.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.data_byte;

    always_comb
    begin
        pos_next        = pos_reg;
        verdict_next    = verdict_reg;
        cap_seq_next    = cap_seq_reg;
        cap_src_next    = cap_src_reg;
        prev_seq_next   = prev_seq_reg;
        locked_src_next = locked_src_reg;
        locked_next     = locked_reg;
        present         = 1'b0;

        if (pos_reg >= rhcs_pkg::HDR_BYTES)
        begin
            present = (verdict_reg == rhcs_pkg::ST_OK);
        end
        else
        begin
            unique case (pos_reg) inside
                rhcs_pkg::POS_VERSION:
                begin
                    verdict_next = (((b & rhcs_pkg::VERSION_MASK) >> 6) ==
                                    {6'd0, rhcs_pkg::RTP_VERSION})
                                   ? rhcs_pkg::ST_OK : rhcs_pkg::ST_VERSION;
                end
                rhcs_pkg::POS_PTYPE:
                begin
                    if ((verdict_reg == rhcs_pkg::ST_OK) &&
                        ((b & rhcs_pkg::PT_MASK) != {1'b0, expected_payload_type}))
                    begin
                        verdict_next = rhcs_pkg::ST_PTYPE;
                    end
                end
                rhcs_pkg::POS_SEQ_HI:
                begin
                    cap_seq_next = {b, cap_seq_reg[7:0]};
                end
                rhcs_pkg::POS_SEQ_LO:
                begin
                    cap_seq_next = {cap_seq_reg[15:8], b};
                end
                [rhcs_pkg::POS_SSRC_FIRST:rhcs_pkg::POS_SSRC_LAST]:
                begin
                    cap_src_next = {cap_src_reg[23:0], b};
                end
                default:
                begin
                end
            endcase

            if ((pos_reg == rhcs_pkg::HDR_LAST) && (verdict_next == rhcs_pkg::ST_OK))
            begin
                if (!locked_reg)
                begin
                    prev_seq_next   = cap_seq_next;
                    locked_src_next = cap_src_next;
                    locked_next     = 1'b1;
                end
                else
                begin
                    prev_seq_next = cap_seq_next;
                    if (cap_seq_next != (prev_seq_reg + 16'd1))
                    begin
                        verdict_next = rhcs_pkg::ST_SEQGAP;
                    end
                    else if (cap_src_next != locked_src_reg)
                    begin
                        verdict_next = rhcs_pkg::ST_SSRC;
                    end
                end
            end
            pos_next = pos_reg + 4'd1;
        end

        push_item.payload_byte    = present ? b : '0;
        push_item.payload_present = present;
        push_item.packet_done     = in_ch.end_of_packet;
        push_item.packet_status   = rhcs_pkg::ST_OK;
        if (in_ch.end_of_packet)
        begin
            push_item.packet_status = (pos_reg < rhcs_pkg::HDR_LAST)
                                      ? rhcs_pkg::ST_SHORT : verdict_next;
            pos_next     = '0;
            verdict_next = rhcs_pkg::ST_OK;
        end
    end

    assign push = accept && (present || in_ch.end_of_packet);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            verdict_reg    <= rhcs_pkg::ST_OK;
            cap_seq_reg    <= '0;
            cap_src_reg    <= '0;
            prev_seq_reg   <= '0;
            locked_src_reg <= '0;
            locked_reg     <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg        <= pos_next;
            verdict_reg    <= verdict_next;
            cap_seq_reg    <= cap_seq_next;
            cap_src_reg    <= cap_src_next;
            prev_seq_reg   <= prev_seq_next;
            locked_src_reg <= locked_src_next;
            locked_reg     <= locked_next;
        end
    end

endmodule

[rtl/core/rhcs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header check result queue
// Small FIFO that decouples the header checker from the output stage.
// ----------------------------------------------------------------------------
module rhcs_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rhcs_pkg::item_t         push_item,
    input  logic                    pop,
    output rhcs_pkg::item_t         pop_item,
    output rhcs_pkg::queue_status_t queue_status
);

    rhcs_pkg::item_t                 mem [rhcs_pkg::QDEPTH];
    logic [rhcs_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [rhcs_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [rhcs_pkg::QCOUNT_W-1:0]   count_reg, count_next;

    assign queue_status.full  = (count_reg == rhcs_pkg::QCOUNT_W'(rhcs_pkg::QDEPTH));
    assign queue_status.empty = (count_reg == '0);
    assign pop_item           = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/rhcs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header check output stage
// Moves queued result items into the output register and onto the channel.
// ----------------------------------------------------------------------------
module rhcs_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  rhcs_pkg::queue_status_t queue_status,
    input  rhcs_pkg::item_t         pop_item,
    output logic                    pop,
    rhcs_out_if.source              out_ch
);

    logic            out_valid_reg;
    rhcs_pkg::item_t out_item_reg;

    assign pop = !queue_status.empty && (!out_valid_reg || out_ch.ready);

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.payload_byte    = out_item_reg.payload_byte;
    assign out_ch.payload_present = out_item_reg.payload_present;
    assign out_ch.packet_done     = out_item_reg.packet_done;
    assign out_ch.packet_status   = out_item_reg.packet_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= pop_item;
        end
    end

endmodule

[tb/rtp_header_check_and_strip_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header check and strip result checker
// Follows every transfer on both channels and every register write, works out
// the results that each packet byte should cause, and compares the results
// that arrive with them in order.
// ----------------------------------------------------------------------------
module rtp_header_check_and_strip_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    rhcs_in_if                                  in_ch,
    rhcs_out_if                                 out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rhcs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rhcs_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic                                pready,
    output int                                  mismatch_count,
    output int                                  results_owed
);

    logic [rhcs_pkg::PT_W-1:0]  want_pt     = '0;
    logic [rhcs_pkg::POS_W-1:0] hdr_pos     = '0;
    rhcs_pkg::status_t          verdict     = rhcs_pkg::ST_OK;
    logic [rhcs_pkg::SEQ_W-1:0] seq_hdr     = '0;
    logic [rhcs_pkg::SEQ_W-1:0] seq_last    = '0;
    logic [rhcs_pkg::SRC_W-1:0] ssrc_hdr    = '0;
    logic [rhcs_pkg::SRC_W-1:0] ssrc_lock   = '0;
    logic                       stream_held = 1'b0;
    rhcs_pkg::item_t            owed_q [$];

    initial
    begin
        mismatch_count = 0;
        results_owed   = 0;
    end

    function automatic void close_header();
        logic [rhcs_pkg::SEQ_W-1:0] follow_seq;
        follow_seq = seq_last + 1'b1;
        if (verdict == rhcs_pkg::ST_OK)
        begin
            if (!stream_held)
            begin
                seq_last    = seq_hdr;
                ssrc_lock   = ssrc_hdr;
                stream_held = 1'b1;
            end
            else
            begin
                seq_last = seq_hdr;
                if (seq_hdr != follow_seq)
                    verdict = rhcs_pkg::ST_SEQGAP;
                else if (ssrc_hdr != ssrc_lock)
                    verdict = rhcs_pkg::ST_SSRC;
            end
        end
    endfunction

    function automatic void strip_byte(input logic [rhcs_pkg::DATA_W-1:0] b,
                                       input logic eop);
        logic [rhcs_pkg::POS_W-1:0] pos;
        logic                       present;
        rhcs_pkg::item_t            res;
        pos     = hdr_pos;
        present = 1'b0;
        if (pos >= rhcs_pkg::HDR_BYTES)
            present = (verdict == rhcs_pkg::ST_OK);
        else
        begin
            case (pos)
                rhcs_pkg::POS_VERSION:
                begin
                    if (b[7:6] == rhcs_pkg::RTP_VERSION)
                        verdict = rhcs_pkg::ST_OK;
                    else
                        verdict = rhcs_pkg::ST_VERSION;
                end
                rhcs_pkg::POS_PTYPE:
                begin
                    if (verdict == rhcs_pkg::ST_OK &&
                        (b & rhcs_pkg::PT_MASK) != {1'b0, want_pt})
                        verdict = rhcs_pkg::ST_PTYPE;
                end
                rhcs_pkg::POS_SEQ_HI: seq_hdr[15:8] = b;
                rhcs_pkg::POS_SEQ_LO: seq_hdr[7:0] = b;
                default:
                begin
                    if (pos >= rhcs_pkg::POS_SSRC_FIRST)
                        ssrc_hdr = {ssrc_hdr[rhcs_pkg::SRC_W-9:0], b};
                end
            endcase
            if (pos == rhcs_pkg::HDR_LAST)
                close_header();
            hdr_pos = pos + 1'b1;
        end
        if (present || eop)
        begin
            res.payload_byte    = present ? b : '0;
            res.payload_present = present;
            res.packet_done     = eop;
            res.packet_status   = rhcs_pkg::ST_OK;
            if (eop)
            begin
                if (pos < rhcs_pkg::HDR_LAST)
                    res.packet_status = rhcs_pkg::ST_SHORT;
                else
                    res.packet_status = verdict;
                hdr_pos = '0;
                verdict = rhcs_pkg::ST_OK;
            end
            owed_q.push_back(res);
        end
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : watch
        rhcs_pkg::item_t want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready &&
                paddr == {rhcs_pkg::REG_EXPECTED_PT, 2'b00})
                want_pt = pwdata[rhcs_pkg::PT_W-1:0];
            if (in_ch.valid && in_ch.ready)
                strip_byte(in_ch.data_byte, in_ch.end_of_packet);
            if (out_ch.valid && out_ch.ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $error({"result transfer with none outstanding: ",
                            "byte %0d present %0d done %0d status %0d"},
                           out_ch.payload_byte, out_ch.payload_present,
                           out_ch.packet_done, out_ch.packet_status);
                    mismatch_count++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
                    check_field("payload_present", 8'(want.payload_present),
                                8'(out_ch.payload_present));
                    check_field("packet_done", 8'(want.packet_done), 8'(out_ch.packet_done));
                    check_field("packet_status", 8'(want.packet_status),
                                8'(out_ch.packet_status));
                end
            end
            results_owed = owed_q.size();
        end
    end

endmodule

[tb/rtp_header_check_and_strip_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header check and strip testbench
// Sends directed packets for every header check, then random streams of mostly
// well-formed packets with broken ones mixed in, under several payload type
// settings and with random gaps on both channels. The checker beside the block
// predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module rtp_header_check_and_strip_test;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned PHASE_BYTES  = 350;
    localparam logic [rhcs_pkg::APB_ADDR_W-1:0] PT_ADDR = {rhcs_pkg::REG_EXPECTED_PT, 2'b00};

    logic                            clk   = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [rhcs_pkg::APB_ADDR_W-1:0] paddr;
    logic [rhcs_pkg::APB_DATA_W-1:0] pwdata;
    logic [rhcs_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    int                              mismatch_count;
    int                              results_owed;
    int unsigned                     cycle_count;

    logic [rhcs_pkg::DATA_W-1:0]     frame_q [$];
    logic                            src_calm  = 1'b0;
    logic                            sink_calm = 1'b0;
    logic [rhcs_pkg::PT_W-1:0]       pt_setting = '0;
    logic [rhcs_pkg::SEQ_W-1:0]      next_seq = '0;
    logic [rhcs_pkg::SRC_W-1:0]      stream_ssrc = '0;
    logic                            stream_up = 1'b0;
    int unsigned                     phase_bytes = 0;

    rhcs_in_if  in_ch();
    rhcs_out_if out_ch();

    rtp_header_check_and_strip dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rtp_header_check_and_strip_checker strip_monitor
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("rtp_header_check_and_strip_test NOT OK");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned hold;
        out_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(out_ch.valid && out_ch.ready))
                @(posedge clk);
            hold = sink_calm ? 0 : $urandom_range(0, 15);
            if (hold > 0)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
                repeat (hold - 1) @(negedge clk);
            end
        end
    end

    task automatic push_byte(input logic [rhcs_pkg::DATA_W-1:0] b, input logic eop);
        int unsigned gap;
        gap = src_calm ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_packet <= eop;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            push_byte(frame_q[i], i == frame_q.size() - 1);
        phase_bytes += frame_q.size();
    endtask

    task automatic build_frame(input logic [1:0] ver, input logic [rhcs_pkg::PT_W-1:0] pt,
                               input logic [rhcs_pkg::SEQ_W-1:0] seq,
                               input logic [rhcs_pkg::SRC_W-1:0] ssrc,
                               input int unsigned plen);
        frame_q.delete();
        frame_q.push_back({ver, 6'($urandom)});
        frame_q.push_back({1'($urandom), pt});
        frame_q.push_back(seq[15:8]);
        frame_q.push_back(seq[7:0]);
        repeat (4) frame_q.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--)
            frame_q.push_back(ssrc[8*i +: 8]);
        repeat (plen) frame_q.push_back(8'($urandom));
    endtask

    task automatic cut_frame(input int unsigned keep);
        while (frame_q.size() > keep)
            void'(frame_q.pop_back());
    endtask

    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_pt(input logic [rhcs_pkg::PT_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PT_ADDR;
        pwdata  <= rhcs_pkg::APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pt_setting = value;
    endtask

    task automatic random_packet();
        int unsigned                kind;
        int unsigned                plen;
        logic [1:0]                 ver;
        logic [rhcs_pkg::PT_W-1:0]  pt;
        logic [rhcs_pkg::SEQ_W-1:0] seq;
        logic [rhcs_pkg::SRC_W-1:0] ssrc;
        kind = $urandom_range(0, 99);
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 64) : $urandom_range(0, 20);
        ver  = rhcs_pkg::RTP_VERSION;
        pt   = pt_setting;
        seq  = next_seq;
        ssrc = stream_ssrc;
        src_calm  = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
        if (kind >= 95 && stream_up)
        begin
            frame_q.delete();
            repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom));
        end
        else
        begin
            if (kind >= 65 && kind < 70)
            begin
                ver = 2'($urandom_range(0, 2));
                if (ver == rhcs_pkg::RTP_VERSION)
                    ver = 2'd3;
            end
            else if (kind >= 70 && kind < 75)
                pt = pt_setting ^ 7'($urandom_range(1, 127));
            else if (kind >= 75 && kind < 82)
            begin
                seq = ($urandom_range(0, 3) == 0) ? 16'hFFFE : 16'($urandom);
                if (seq == next_seq)
                    seq = seq + 16'd2;
            end
            else if (kind >= 82 && kind < 88 && stream_up)
                ssrc = stream_ssrc ^ (32'($urandom) | 32'd1);
            build_frame(ver, pt, seq, ssrc, plen);
            if (kind >= 88 && kind < 95)
                cut_frame($urandom_range(1, 11));
            else if (ver == rhcs_pkg::RTP_VERSION && pt == pt_setting)
            begin
                next_seq = seq + 1'b1;
                if (!stream_up)
                begin
                    stream_up   = 1'b1;
                    stream_ssrc = ssrc;
                end
            end
        end
        send_frame();
    endtask

    initial
    begin
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = '0;
        in_ch.end_of_packet = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_pt(7'd0);
        stream_ssrc = $urandom;

        frame_q.delete();
        frame_q.push_back(8'hFF);
        send_frame();

        build_frame(rhcs_pkg::RTP_VERSION, pt_setting, 16'hFFFE, stream_ssrc, 0);
        cut_frame(11);
        send_frame();

        // The first good packet locks the stream; the next two cross the sequence wrap.
        build_frame(rhcs_pkg::RTP_VERSION, pt_setting, 16'hFFFE, stream_ssrc, 0);
        send_frame();
        build_frame(rhcs_pkg::RTP_VERSION, pt_setting, 16'hFFFF, stream_ssrc, 2);
        frame_q[12] = 8'h00;
        frame_q[13] = 8'hFF;
        send_frame();
        build_frame(rhcs_pkg::RTP_VERSION, pt_setting, 16'h0000, stream_ssrc, 1);
        send_frame();

        build_frame(2'd0, pt_setting, 16'h0001, stream_ssrc, 2);
        send_frame();
        build_frame(rhcs_pkg::RTP_VERSION, 7'h7F, 16'h0001, stream_ssrc, 2);
        send_frame();
        build_frame(rhcs_pkg::RTP_VERSION, pt_setting, 16'h1234, stream_ssrc, 1);
        send_frame();
        build_frame(rhcs_pkg::RTP_VERSION, pt_setting, 16'h1235, ~stream_ssrc, 1);
        send_frame();
        build_frame(rhcs_pkg::RTP_VERSION, pt_setting, 16'h1236, stream_ssrc, 3);
        send_frame();
        next_seq  = 16'h1237;
        stream_up = 1'b1;

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: write_pt(7'd127);
                1: write_pt(7'd0);
                2: write_pt(7'd96);
                default: write_pt(7'($urandom));
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
                random_packet();
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        for (int n = 0; n < 2000 && results_owed != 0; n++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (results_owed != 0)
            $error("%0d expected results never arrived", results_owed);
        if (mismatch_count == 0 && results_owed == 0)
            $display("rtp_header_check_and_strip_test OK");
        else
            $display("rtp_header_check_and_strip_test NOT OK");
        $finish;
    end

endmodule
